// ===== hw/rtl/heap_sorter_defines.svh =====
// assertion macros for the heap sorter checker
`ifndef HEAP_SORTER_DEFINES_SVH
`define HEAP_SORTER_DEFINES_SVH
`define HS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("heap sorter port check failed");
`define HS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("heap sorter port check failed");
`endif

// ===== hw/rtl/hs_pkg.sv =====
// shared constants and compare functions of the heap sorter
package hs_pkg;
    localparam logic [2:0] KT_U8  = 3'd0;
    localparam logic [2:0] KT_U16 = 3'd1;
    localparam logic [2:0] KT_U32 = 3'd2;
    localparam logic [2:0] KT_U64 = 3'd3;
    localparam logic [2:0] KT_F32 = 3'd4;
    localparam logic [2:0] KT_F64 = 3'd5;
    localparam logic CFG_DIR = 1'b0;
    localparam logic CFG_KTYPE = 1'b1;

    function automatic logic f_fgt(input logic [63:0] x, input logic [63:0] y,
                                   input logic dbl);
        logic sx, sy, nx, ny, zx, zy;
        logic [63:0] ox, oy, mx, my, sg, mm;
        begin
            if (dbl) begin
                sx = x[63]; sy = y[63];
                nx = (&x[62:52]) && (|x[51:0]);
                ny = (&y[62:52]) && (|y[51:0]);
                mx = {1'b0, x[62:0]}; my = {1'b0, y[62:0]};
                sg = 64'h8000_0000_0000_0000;
                mm = 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
                sx = x[31]; sy = y[31];
                nx = (&x[30:23]) && (|x[22:0]);
                ny = (&y[30:23]) && (|y[22:0]);
                mx = {33'd0, x[30:0]}; my = {33'd0, y[30:0]};
                sg = 64'h0000_0000_8000_0000;
                mm = 64'h0000_0000_7FFF_FFFF;
            end
            zx = (mx == 64'd0);
            zy = (my == 64'd0);
            ox = sx ? (~mx & mm) : (mx | sg);
            oy = sy ? (~my & mm) : (my | sg);
            f_fgt = !(nx || ny || (zx && zy)) && (ox > oy);
        end
    endfunction

    function automatic logic f_gt(input logic [63:0] x, input logic [63:0] y,
                                  input logic [2:0] kt);
        begin
            case (kt)
                KT_U8:   f_gt = x[7:0] > y[7:0];
                KT_U16:  f_gt = x[15:0] > y[15:0];
                KT_U32:  f_gt = x[31:0] > y[31:0];
                KT_U64:  f_gt = x > y;
                KT_F32:  f_gt = f_fgt(x, y, 1'b0);
                KT_F64:  f_gt = f_fgt(x, y, 1'b1);
                default: f_gt = 1'b0;
            endcase
        end
    endfunction
endpackage

// ===== hw/rtl/hs_store.sv =====
// record memory, one write port and one registered read port
module hs_store import hs_pkg::*; #(
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [79:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [79:0]   o_rdata
);
    logic [79:0] r_mem [0:(1<<AW)-1];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/heap_sorter.sv =====
// heap sorter top level: load, heapsort sequencer and output
// sequence: load takes one record per cycle; after the last request the sort runs up to
// the states S_SIFT through S_WR2 per sift level plus S_SWRD through S_SWC per root swap,
// about n*log2(n) levels in all, then reads out each result in S_OUTRD and S_OUT
// pacing: the sort is set by the single read and write port of the record memory; a new
// set of records is taken only after the last result of the previous set is out
// reset: synchronous active low, clears count, overflow, direction, output valid and sequencer; key type goes to KT_U64
module heap_sorter import hs_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_sort_key,
    input  logic [15:0] i_record_tag,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_sorted_key,
    output logic [15:0] o_sorted_tag,
    output logic        o_last_out,
    output logic        o_overflow_flag
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_BUILD, S_SIFT, S_RDL, S_RDR, S_CMPL, S_CMPR, S_WR1, S_WR2,
        S_SWRD, S_SWA, S_SWB, S_SWC, S_OUTRD, S_OUT
    } t_state;

    t_state r_state;
    logic r_dir;
    logic [2:0] r_kt;
    logic [CW-1:0] r_cnt, r_n, r_bi, r_node, r_best, r_k;
    logic r_ovf, r_build;
    logic [79:0] r_nv, r_bv, r_tmp;
    logic [CW:0] w_lc, w_rc;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [79:0] wdata, rdata;

    hs_store #(.AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign w_lc = {r_node, 1'b0} + (CW+1)'(1);
    assign w_rc = {r_node, 1'b0} + (CW+1)'(2);
    assign o_ready = (r_state == S_LOAD);

    function automatic logic f_after(input logic [79:0] a, input logic [79:0] b,
                                     input logic d, input logic [2:0] kt);
        f_after = d ? f_gt(b[79:16], a[79:16], kt) : f_gt(a[79:16], b[79:16], kt);
    endfunction

    always_comb begin
        we = 1'b0;
        waddr = r_cnt[AW-1:0];
        wdata = {i_sort_key, i_record_tag};
        raddr = r_node[AW-1:0];
        case (r_state)
            S_LOAD: begin
                we = i_valid && (r_cnt < CW'(CAPACITY));
            end
            S_RDL: raddr = w_lc[AW-1:0];
            S_RDR: raddr = w_rc[AW-1:0];
            S_WR1: begin
                we = 1'b1; waddr = r_node[AW-1:0]; wdata = r_bv;
            end
            S_WR2: begin
                we = 1'b1; waddr = r_best[AW-1:0]; wdata = r_nv;
            end
            S_SWRD: raddr = AW'(r_n - CW'(1));
            S_SWA: raddr = '0;
            S_SWB: begin
                we = 1'b1; waddr = '0; wdata = r_tmp;
            end
            S_SWC: begin
                we = 1'b1; waddr = r_n[AW-1:0]; wdata = r_nv;
            end
            S_OUTRD: raddr = r_k[AW-1:0];
            S_OUT: raddr = r_k[AW-1:0];
            default: ;
        endcase
    end

    // root/last swap: S_SWRD reads last, S_SWA reads root and latches last,
    // S_SWB writes last to root, S_SWC writes root to last, then sift from root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_dir <= 1'b0;
            r_kt <= KT_U64;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            o_valid <= 1'b0;
            r_build <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIR:   r_dir <= i_cfg_data[0];
                    CFG_KTYPE: r_kt <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (r_cnt < CW'(CAPACITY)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_item) begin
                            if (r_cnt < CW'(CAPACITY)) begin
                                r_n <= r_cnt + CW'(1);
                                r_bi <= (r_cnt + CW'(1)) >> 1;
                            end else begin
                                r_n <= r_cnt;
                                r_bi <= r_cnt >> 1;
                            end
                            r_build <= 1'b1;
                            r_state <= S_BUILD;
                        end
                    end
                end
                S_BUILD: begin
                    if (r_bi == '0) begin
                        r_build <= 1'b0;
                        if (r_n > CW'(1)) begin
                            r_state <= S_SWRD;
                        end else begin
                            r_k <= '0;
                            r_state <= S_OUTRD;
                        end
                    end else begin
                        r_node <= r_bi - CW'(1);
                        r_bi <= r_bi - CW'(1);
                        r_state <= S_SIFT;
                    end
                end
                S_SIFT: r_state <= S_RDL;
                S_RDL: begin
                    r_nv <= rdata;
                    r_bv <= rdata;
                    r_best <= r_node;
                    if (w_lc < {1'b0, r_n}) begin
                        r_state <= S_RDR;
                    end else begin
                        r_state <= r_build ? S_BUILD : S_SWRD;
                    end
                end
                S_RDR: begin
                    if (f_after(rdata, r_bv, r_dir, r_kt)) begin
                        r_bv <= rdata; r_best <= w_lc[CW-1:0];
                    end
                    r_state <= S_CMPL;
                end
                S_CMPL: begin
                    if (w_rc < {1'b0, r_n} && f_after(rdata, r_bv, r_dir, r_kt)) begin
                        r_bv <= rdata; r_best <= w_rc[CW-1:0];
                    end
                    r_state <= S_CMPR;
                end
                S_CMPR: begin
                    if (r_best == r_node) begin
                        r_state <= r_build ? S_BUILD : S_SWRD;
                    end else begin
                        r_state <= S_WR1;
                    end
                end
                S_WR1: r_state <= S_WR2;
                S_WR2: begin
                    r_node <= r_best;
                    r_state <= S_SIFT;
                end
                S_SWRD: begin
                    if (r_n <= CW'(1)) begin
                        r_k <= '0;
                        r_state <= S_OUTRD;
                    end else begin
                        r_state <= S_SWA;
                    end
                end
                S_SWA: begin
                    r_tmp <= rdata;
                    r_state <= S_SWB;
                end
                S_SWB: begin
                    r_nv <= rdata;
                    r_node <= '0;
                    r_n <= r_n - CW'(1);
                    r_state <= S_SWC;
                end
                S_SWC: r_state <= S_SIFT;
                S_OUTRD: begin
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        if (r_k == r_cnt) begin
                            if (!o_valid || i_ready) begin
                                o_valid <= 1'b0;
                                r_cnt <= '0;
                                r_ovf <= 1'b0;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            o_valid <= 1'b1;
                            o_sorted_key <= rdata[79:16];
                            o_sorted_tag <= rdata[15:0];
                            o_last_out <= (r_k + CW'(1) == r_cnt);
                            o_overflow_flag <= r_ovf;
                            r_k <= r_k + CW'(1);
                            r_state <= S_OUTRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ===== hw/rtl/hs_checker.sv =====
// port checker for the heap sorter, bound to the top level
`include "heap_sorter_defines.svh"
module hs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_sorted_key,
    input logic        o_last_out
);
    `HS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sorted_key))
    `HS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `HS_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_last_out, !o_valid)
endmodule

bind heap_sorter hs_checker u_hs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_sorted_key(o_sorted_key),
    .o_last_out(o_last_out)
);
